// ----- src/bstt_pkg.sv -----
// Shared types, constants and helpers for the belief set transition tracker.
`timescale 1ns / 1ps

package bstt_pkg;

	localparam int MAX_STATES  = 64;
	localparam int MAX_ACTIONS = 16;

	localparam int SET_W     = 64;
	localparam int STATE_W   = 6;
	localparam int ACTION_W  = 4;
	localparam int FUNC_W    = 2;
	localparam int SC_W      = 7;
	localparam int AC_W      = 5;
	localparam int COUNT_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;

	localparam int SUCC_DEPTH = 2 ** (ACTION_W + STATE_W);

	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WATCH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTION_COUNT = 1'd1;

	localparam logic [SC_W-1:0] STATE_COUNT_RESET  = SC_W'(MAX_STATES);
	localparam logic [AC_W-1:0] ACTION_COUNT_RESET = AC_W'(MAX_ACTIONS);

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [ACTION_W-1:0] action_index;
		logic [STATE_W-1:0]  from_state;
		logic [STATE_W-1:0]  to_state;
		logic [SET_W-1:0]    current_set;
	} cmd_t;

	typedef struct packed {
		logic               status;
		logic [SET_W-1:0]   next_set;
		logic [COUNT_W-1:0] unwatched_count;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN
	} fsm_t;

	// set of the states below the configured count
	function automatic logic [SET_W-1:0] full_mask(input logic [SC_W-1:0] n);
		logic [SET_W-1:0] m;
		for (int i = 0; i < SET_W; i++) begin
			m[i] = (SC_W'(i) < n);
		end
		return m;
	endfunction

endpackage

// ----- src/bstt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bstt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/belief_set_transition_tracker_core.sv -----
// Top level of the belief set transition tracker.
`timescale 1ns / 1ps

// Usage:
// A command word is taken at a rising edge with start high and busy low.
// Each command gives exactly one result word, shown on result for one cycle
// with done high; the receiver cannot stall it, so it must take it then.
// Clear, invalid and unknown commands answer in the cycle after acceptance and
// leave busy low, so a new command can follow at once.
// A watch does a read-modify-write of one successor word and is busy in its
// write state. A step walks states 0 .. state_count-1, one successor memory
// read per cycle, and gives its result after a drain state that follows the
// last read; the successor memory has a single read port.
// The configuration port writes state_count (index 0) and action_count
// (index 1) on any edge with cfg_we high; out-of-range values are dropped,
// action_count being judged on cfg_data[4:0] only. Reset sets both counts to
// their maxima and empties the watched masks.
// The successor memory needs no clearing pass: an entry is only read once its
// watched bit is set, and the first watch of an entry overwrites it.

module belief_set_transition_tracker_core
	import bstt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	fsm_t state_q, state_d;

	logic [SC_W-1:0]  sc_q;
	logic [AC_W-1:0]  ac_q;
	logic [SET_W-1:0] watched_q [MAX_ACTIONS];

	logic [ACTION_W-1:0] act_q;
	logic [STATE_W-1:0]  from_q;
	logic [STATE_W-1:0]  to_q;
	logic                seen_q;
	logic [SET_W-1:0]    set_q;
	logic [SET_W-1:0]    wmask_q;
	logic [STATE_W-1:0]  idx_q;
	logic                hit_s1;
	logic [SET_W-1:0]    acc_q;
	logic [COUNT_W-1:0]  miss_q;
	logic                done_q;
	result_t             result_q;

	logic                              accept;
	logic                              act_ok;
	logic                              watch_ok;
	logic                              step_ok;
	logic [STATE_W-1:0]                last_idx;
	logic [SET_W-1:0]                  fmask;
	logic [SET_W-1:0]                  to_bit;
	logic                              ram_we;
	logic [ACTION_W+STATE_W-1:0]       ram_waddr;
	logic [ACTION_W+STATE_W-1:0]       ram_raddr;
	logic [SET_W-1:0]                  ram_wdata;
	logic [SET_W-1:0]                  ram_rdata;
	logic [SET_W-1:0]                  step_set;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign act_ok   = ({1'b0, cmd.action_index} < ac_q);
	assign watch_ok = (cmd.func == FUNC_WATCH) && act_ok
		&& ({1'b0, cmd.from_state} < sc_q) && ({1'b0, cmd.to_state} < sc_q);
	assign step_ok  = (cmd.func == FUNC_STEP) && act_ok;
	assign last_idx = STATE_W'(sc_q - SC_W'(1));
	assign fmask    = full_mask(sc_q);
	assign to_bit   = SET_W'(1) << to_q;

	// first watch of an entry overwrites whatever the memory held
	assign ram_we    = (state_q == ST_WRITE);
	assign ram_waddr = {act_q, from_q};
	assign ram_wdata = seen_q ? (ram_rdata | to_bit) : to_bit;
	assign ram_raddr = (state_q == ST_SCAN) ? {act_q, idx_q}
		: {cmd.action_index, cmd.from_state};

	bstt_ram #(
		.WIDTH (SET_W),
		.DEPTH (SUCC_DEPTH)
	) u_succ_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && watch_ok) begin
					state_d = ST_WRITE;
				end else if (accept && step_ok) begin
					state_d = ST_SCAN;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_SCAN: begin
				if (idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= STATE_COUNT_RESET;
			ac_q   <= ACTION_COUNT_RESET;
			done_q <= 1'b0;
			for (int a = 0; a < MAX_ACTIONS; a++) begin
				watched_q[a] <= '0;
			end
		end else begin
			done_q <= (accept && !watch_ok && !step_ok)
				|| (state_q == ST_WRITE) || (state_q == ST_DRAIN);
			if (cfg_we) begin
				case (cfg_index)
					REG_STATE_COUNT: begin
						if (cfg_data != '0 && cfg_data <= CFG_W'(MAX_STATES)) begin
							sc_q <= SC_W'(cfg_data);
						end
					end
					REG_ACTION_COUNT: begin
						if (cfg_data[AC_W-1:0] != '0
							&& cfg_data[AC_W-1:0] <= AC_W'(MAX_ACTIONS)) begin
							ac_q <= cfg_data[AC_W-1:0];
						end
					end
					default: ;
				endcase
			end
			if (accept) begin
				if (cmd.func == FUNC_CLEAR) begin
					for (int a = 0; a < MAX_ACTIONS; a++) begin
						watched_q[a] <= '0;
					end
				end else if (watch_ok) begin
					watched_q[cmd.action_index][cmd.from_state] <= 1'b1;
				end
			end
		end
	end

	assign step_set = cmd.current_set & fmask;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= cmd.action_index;
			from_q   <= cmd.from_state;
			to_q     <= cmd.to_state;
			seen_q   <= watched_q[cmd.action_index][cmd.from_state];
			set_q    <= step_set;
			wmask_q  <= watched_q[cmd.action_index];
			idx_q    <= '0;
			hit_s1   <= 1'b0;
			acc_q    <= '0;
			miss_q   <= '0;
			result_q <= '{status: (cmd.func != FUNC_CLEAR), next_set: '0,
				unwatched_count: '0};
		end
		case (state_q)
			ST_WRITE: begin
				result_q <= '{status: 1'b0, next_set: '0, unwatched_count: '0};
			end
			ST_SCAN: begin
				// successor word for the previous index lands now
				if (hit_s1) begin
					acc_q <= acc_q | ram_rdata;
				end
				hit_s1 <= set_q[idx_q] & wmask_q[idx_q];
				miss_q <= miss_q + COUNT_W'(set_q[idx_q] & ~wmask_q[idx_q]);
				idx_q  <= idx_q + STATE_W'(1);
			end
			ST_DRAIN: begin
				result_q.status          <= 1'b0;
				result_q.unwatched_count <= miss_q;
				if (miss_q != '0) begin
					result_q.next_set <= fmask;
				end else if (hit_s1) begin
					result_q.next_set <= (acc_q | ram_rdata) & fmask;
				end else begin
					result_q.next_set <= acc_q & fmask;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
